[hw/rtl/lcg48_pkg.sv]
// Package for the 48-bit LCG generator: codes, microcode control word and program table.
`default_nettype none
package lcg48_pkg;

    // LCG constants
    localparam int SEED_BITS = 48;
    localparam logic [34:0] LCG_MUL = 35'h5DEECE66D;
    localparam logic [SEED_BITS-1:0] LCG_ADD = 48'hB;
    localparam logic [SEED_BITS-1:0] SEED_RESET = 48'h5DEECE66D;

    // Width of one bounded draw and of the divider count
    localparam int U_BITS = 31;
    localparam logic [4:0] DIV_LAST = 5'(U_BITS - 1);

    // Biased exponents for a mantissa normalized at bit 52
    localparam logic [10:0] EXP_FLOAT_INIT = 11'd126;
    localparam logic [10:0] EXP_DOUBLE_INIT = 11'd1022;

    // Request codes
    localparam logic [2:0] FUNC_RESEED = 3'd0;
    localparam logic [2:0] FUNC_INT32 = 3'd1;
    localparam logic [2:0] FUNC_BOUNDED = 3'd2;
    localparam logic [2:0] FUNC_INT64 = 3'd3;
    localparam logic [2:0] FUNC_BOOL = 3'd4;
    localparam logic [2:0] FUNC_FLOAT = 3'd5;
    localparam logic [2:0] FUNC_DOUBLE = 3'd6;

    // Program addresses that are entered or jumped to
    localparam logic [5:0] A_RESEED = 6'd0;
    localparam logic [5:0] A_IDLE_FUNC = 6'd1;
    localparam logic [5:0] A_FIN = 6'd2;
    localparam logic [5:0] A_INT32 = 6'd3;
    localparam logic [5:0] A_BOOL = 6'd6;
    localparam logic [5:0] A_INT64 = 6'd9;
    localparam logic [5:0] A_BOUNDED = 6'd15;
    localparam logic [5:0] A_BND_DRAW = 6'd16;
    localparam logic [5:0] A_DIVSTEP = 6'd20;
    localparam logic [5:0] A_PMUL = 6'd22;
    localparam logic [5:0] A_FLOAT = 6'd23;
    localparam logic [5:0] A_FNORM = 6'd27;
    localparam logic [5:0] A_DOUBLE = 6'd29;
    localparam logic [5:0] A_DNORM = 6'd36;
    localparam logic [5:0] A_LAST = 6'd37;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_RESEED,
        OP_ZERO,
        OP_MUL,
        OP_ADV,
        OP_INT32,
        OP_BOOL,
        OP_HI32,
        OP_LO32,
        OP_CHKB,
        OP_R31,
        OP_PMUL,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_REJ,
        OP_F24,
        OP_D26,
        OP_D27,
        OP_ZCHK,
        OP_NORM,
        OP_PACKF,
        OP_PACKD
    } t_op;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_NEG,
        JC_POW2,
        JC_DIVMORE,
        JC_REJECT,
        JC_XZERO,
        JC_NOTNORM
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_cond      cond;
        logic [5:0] target;
        logic       last;
    } t_cw;

    function automatic t_cw f_cw(t_op op, t_cond cond, logic [5:0] target, logic last);
        t_cw w;
        w.op = op;
        w.cond = cond;
        w.target = target;
        w.last = last;
        return w;
    endfunction

    // Program table: one control word per step
    function automatic t_cw f_rom(logic [5:0] pc);
        t_cw w;
        case (pc)
            6'd0:  w = f_cw(OP_RESEED,  JC_NONE,    A_FIN,      1'b1);
            6'd1:  w = f_cw(OP_ZERO,    JC_NONE,    A_FIN,      1'b1);
            6'd2:  w = f_cw(OP_NOP,     JC_NONE,    A_FIN,      1'b1);
            // int32
            6'd3:  w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd4:  w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd5:  w = f_cw(OP_INT32,   JC_NONE,    A_FIN,      1'b1);
            // boolean
            6'd6:  w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd7:  w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd8:  w = f_cw(OP_BOOL,    JC_NONE,    A_FIN,      1'b1);
            // int64
            6'd9:  w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd10: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd11: w = f_cw(OP_HI32,    JC_NONE,    A_FIN,      1'b0);
            6'd12: w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd13: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd14: w = f_cw(OP_LO32,    JC_NONE,    A_FIN,      1'b1);
            // bounded int
            6'd15: w = f_cw(OP_CHKB,    JC_NEG,     A_FIN,      1'b0);
            6'd16: w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd17: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd18: w = f_cw(OP_R31,     JC_POW2,    A_PMUL,     1'b0);
            6'd19: w = f_cw(OP_DIVINIT, JC_NONE,    A_FIN,      1'b0);
            6'd20: w = f_cw(OP_DIVSTEP, JC_DIVMORE, A_DIVSTEP,  1'b0);
            6'd21: w = f_cw(OP_REJ,     JC_REJECT,  A_BND_DRAW, 1'b1);
            6'd22: w = f_cw(OP_PMUL,    JC_NONE,    A_FIN,      1'b1);
            // float
            6'd23: w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd24: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd25: w = f_cw(OP_F24,     JC_NONE,    A_FIN,      1'b0);
            6'd26: w = f_cw(OP_ZCHK,    JC_XZERO,   A_FIN,      1'b0);
            6'd27: w = f_cw(OP_NORM,    JC_NOTNORM, A_FNORM,    1'b0);
            6'd28: w = f_cw(OP_PACKF,   JC_NONE,    A_FIN,      1'b1);
            // double
            6'd29: w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd30: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd31: w = f_cw(OP_D26,     JC_NONE,    A_FIN,      1'b0);
            6'd32: w = f_cw(OP_MUL,     JC_NONE,    A_FIN,      1'b0);
            6'd33: w = f_cw(OP_ADV,     JC_NONE,    A_FIN,      1'b0);
            6'd34: w = f_cw(OP_D27,     JC_NONE,    A_FIN,      1'b0);
            6'd35: w = f_cw(OP_ZCHK,    JC_XZERO,   A_FIN,      1'b0);
            6'd36: w = f_cw(OP_NORM,    JC_NOTNORM, A_DNORM,    1'b0);
            6'd37: w = f_cw(OP_PACKD,   JC_NONE,    A_FIN,      1'b1);
            default: w = f_cw(OP_NOP,   JC_NONE,    A_FIN,      1'b1);
        endcase
        return w;
    endfunction

    // Entry point of the program for each request code
    function automatic logic [5:0] f_entry(logic [2:0] func);
        logic [5:0] a;
        case (func)
            FUNC_RESEED:  a = A_RESEED;
            FUNC_INT32:   a = A_INT32;
            FUNC_BOUNDED: a = A_BOUNDED;
            FUNC_INT64:   a = A_INT64;
            FUNC_BOOL:    a = A_BOOL;
            FUNC_FLOAT:   a = A_FLOAT;
            FUNC_DOUBLE:  a = A_DOUBLE;
            default:      a = A_IDLE_FUNC;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lcg48_random_generator.sv]
// Top level: microcoded 48-bit LCG generator for reseed, int, bounded, long, boolean, float, double.
// Steps: reseed; int32 and boolean draw once, int64 twice; a negative bound gives zero with
// o_bad_bound set; a power-of-two bound uses multiply-shift, any other bound 31 one-bit divider
// steps plus a redraw for each rejected draw; float and double normalize their draw, and a zero
// draw skips normalizing and gives zero. A request is taken only while none is in progress;
// a new word is taken while the last result still waits on the output, and a stalled output
// word holds the finishing step. Each draw is two steps.
// Reset (synchronous, active low) sets the seed to 0x5DEECE66D and empties both sides.
`default_nettype none
module lcg48_random_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [47:0] i_seed_value,
    input  wire logic [31:0] i_bound,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_value,
    output logic             o_bad_bound
);
    import lcg48_pkg::*;

    // control state
    logic        r_busy;
    logic [5:0]  r_pc;
    logic        r_out_valid;
    logic [63:0] r_value;
    logic        r_bad_out;

    // datapath registers
    logic [47:0] r_seed, n_seed;
    logic [47:0] r_sv;
    logic [31:0] r_bound;
    logic [47:0] r_pa, n_pa;
    logic [23:0] r_pb, n_pb;
    logic [63:0] r_val, n_val;
    logic        r_bad, n_bad;
    logic [30:0] r_u, n_u;
    logic [30:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic [52:0] r_x, n_x;
    logic [10:0] r_exp, n_exp;

    t_cw         cw;
    logic        in_acc;
    logic        jump;
    logic        fin_now;
    logic        out_free;
    logic        step_en;
    logic [58:0] prod_lo;
    logic [47:0] prod_hi;
    logic [62:0] prod_b;
    logic [31:0] rem_sh;
    logic [31:0] rej_sum;
    logic [31:0] bound_m1;

    assign cw = f_rom(r_pc);
    assign in_acc = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || !i_out_stall;

    // LCG partial products: low half times full multiplier, high half times its low 24 bits
    assign prod_lo = r_seed[23:0] * LCG_MUL;
    assign prod_hi = r_seed[47:24] * LCG_MUL[23:0];
    assign prod_b = r_bound * r_u;

    assign bound_m1 = r_bound - 32'd1;
    assign rem_sh = {r_rem[30:0], r_q[30]};
    assign rej_sum = {1'b0, r_u} - r_rem + bound_m1;

    // evaluate the step's jump condition
    always_comb begin
        case (cw.cond)
            JC_NONE:    jump = 1'b0;
            JC_NEG:     jump = r_bound[31];
            JC_POW2:    jump = (r_bound & bound_m1) == 32'd0;
            JC_DIVMORE: jump = r_cnt != 5'd0;
            JC_REJECT:  jump = rej_sum[31];
            JC_XZERO:   jump = r_x == 53'd0;
            JC_NOTNORM: jump = !r_x[52];
            default:    jump = 1'b0;
        endcase
    end

    assign fin_now = r_busy && !jump && cw.last;
    assign step_en = r_busy && !(fin_now && !out_free);

    // datapath operation of the current step
    always_comb begin
        n_seed = r_seed;
        n_pa = r_pa;
        n_pb = r_pb;
        n_val = r_val;
        n_bad = r_bad;
        n_u = r_u;
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_x = r_x;
        n_exp = r_exp;
        case (cw.op)
            OP_NOP: begin
            end
            OP_RESEED: begin
                n_seed = r_sv ^ SEED_RESET;
                n_val = 64'd0;
            end
            OP_ZERO: n_val = 64'd0;
            OP_MUL: begin
                n_pa = prod_lo[47:0];
                n_pb = prod_hi[23:0];
            end
            OP_ADV: n_seed = r_pa + {r_pb, 24'd0} + LCG_ADD;
            OP_INT32: n_val = {{32{r_seed[47]}}, r_seed[47:16]};
            OP_BOOL: n_val = {63'd0, r_seed[47]};
            OP_HI32: n_val = {r_seed[47:16], 32'd0};
            OP_LO32: n_val = r_val + {{32{r_seed[47]}}, r_seed[47:16]};
            OP_CHKB: begin
                n_bad = r_bound[31];
                n_val = 64'd0;
            end
            OP_R31: n_u = r_seed[47:17];
            OP_PMUL: n_val = {33'd0, prod_b[61:31]};
            OP_DIVINIT: begin
                n_rem = 32'd0;
                n_q = r_u;
                n_cnt = DIV_LAST;
            end
            OP_DIVSTEP: begin
                n_rem = (rem_sh >= r_bound) ? rem_sh - r_bound : rem_sh;
                n_q = {r_q[29:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
            end
            OP_REJ: n_val = {32'd0, r_rem};
            OP_F24: begin
                n_x = {r_seed[47:24], 29'd0};
                n_exp = EXP_FLOAT_INIT;
            end
            OP_D26: n_x = {27'd0, r_seed[47:22]};
            OP_D27: begin
                n_x = {r_x[25:0], r_seed[47:21]};
                n_exp = EXP_DOUBLE_INIT;
            end
            OP_ZCHK: n_val = 64'd0;
            OP_NORM: begin
                if (!r_x[52]) begin
                    if (r_x[52:49] == 4'd0) begin
                        n_x = {r_x[48:0], 4'd0};
                        n_exp = r_exp - 11'd4;
                    end else begin
                        n_x = {r_x[51:0], 1'b0};
                        n_exp = r_exp - 11'd1;
                    end
                end
            end
            OP_PACKF: n_val = {32'd0, 1'b0, r_exp[7:0], r_x[51:29]};
            OP_PACKD: n_val = {1'b0, r_exp, r_x[51:0]};
            default: begin
            end
        endcase
    end

    // sequencer, seed and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc <= A_FIN;
            r_out_valid <= 1'b0;
            r_seed <= SEED_RESET;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_busy <= 1'b1;
                r_pc <= f_entry(i_func);
            end else if (step_en) begin
                r_seed <= n_seed;
                if (jump) begin
                    r_pc <= cw.target;
                end else if (cw.last) begin
                    r_busy <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_value <= n_val;
                    r_bad_out <= n_bad;
                end else begin
                    r_pc <= r_pc + 6'd1;
                end
            end
        end
    end

    // request fields and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sv <= i_seed_value;
            r_bound <= i_bound;
            r_bad <= 1'b0;
        end else if (step_en) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_val <= n_val;
            r_bad <= n_bad;
            r_u <= n_u;
            r_q <= n_q;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
            r_x <= n_x;
            r_exp <= n_exp;
        end
    end

    assign o_in_stall = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_value = r_value;
    assign o_bad_bound = r_bad_out;

    // program counter never leaves the table
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= A_LAST)
        else $error("program counter outside table");

    // a bad bound always comes with a zero value
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bad_out |-> r_value == 64'd0)
        else $error("bad bound with nonzero value");

    // remainder stays below the bound through the divider
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (cw.op == OP_DIVSTEP || cw.op == OP_REJ) |-> r_rem < r_bound)
        else $error("remainder not below bound");

    // a finished result waiting on a stalled output holds the sequencer
    a_hold_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_now && r_out_valid && i_out_stall |=> r_busy && $stable(r_pc))
        else $error("result finished over a stalled output word");

endmodule
`default_nettype wire

[tb/tb_lcg48_random_generator.sv]
`timescale 1ns / 1ps
// Testbench for the 48-bit LCG generator: directed and random requests against a built-in predictor.
module tb_lcg48_random_generator;
    import lcg48_pkg::*;

    localparam logic [47:0] LCG_MULT = 48'h5DEECE66D;
    localparam logic [47:0] LCG_INC = 48'hB;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [63:0] value;
        logic        bad_bound;
    } rng_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_func = FUNC_RESEED;
    logic [47:0] i_seed_value = '0;
    logic [31:0] i_bound = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_value;
    logic        o_bad_bound;

    lcg48_random_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_seed_value (i_seed_value),
        .i_bound      (i_bound),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_bad_bound  (o_bad_bound)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state and result words still owed by the block
    logic [47:0] model_seed = SEED_RESET;
    rng_word_t   rng_results_due[$];

    bit in_gaps_on = 1'b0;
    bit out_gaps_on = 1'b0;
    int stall_left = 0;
    int mismatch_count = 0;
    int words_checked = 0;
    int redraw_count = 0;
    int bad_bound_count = 0;
    int zero_fp_count = 0;
    int func_hits[8];

    // Advance the seed and return its top bits
    function automatic logic [31:0] next_bits(int nbits);
        model_seed = model_seed * LCG_MULT + LCG_INC;
        return 32'(model_seed >> (48 - nbits));
    endfunction

    function automatic int msb_index(logic [63:0] x);
        int p;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0)
            p++;
        return p;
    endfunction

    // Bounded int: multiply-shift for powers of two, else modulo with rejection
    function automatic logic [31:0] bounded_draw(logic [31:0] b);
        logic [31:0] r;
        logic [31:0] u;
        logic [63:0] prod;
        r = next_bits(31);
        if ((b & (b - 32'd1)) == 32'd0) begin
            prod = 64'(b) * 64'(r);
            return prod[62:31];
        end
        u = r;
        forever begin
            r = u % b;
            if (((u - r + (b - 32'd1)) & 32'h8000_0000) == 32'd0)
                break;
            u = next_bits(31);
            redraw_count++;
        end
        return r;
    endfunction

    // Exact IEEE single pattern of next(24) * 2^-24
    function automatic logic [63:0] float_pattern();
        logic [31:0] x;
        int p;
        x = next_bits(24);
        if (x == 32'd0) begin
            zero_fp_count++;
            return 64'd0;
        end
        p = msb_index(64'(x));
        return (64'(p + 103) << 23) | ((64'(x) << (23 - p)) & 64'h7F_FFFF);
    endfunction

    // Exact IEEE double pattern of the 53-bit draw times 2^-53
    function automatic logic [63:0] double_pattern();
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] x;
        int p;
        hi = 64'(next_bits(26));
        lo = 64'(next_bits(27));
        x = (hi << 27) + lo;
        if (x == 64'd0) begin
            zero_fp_count++;
            return 64'd0;
        end
        p = msb_index(x);
        return (64'(p + 970) << 52) | ((x << (52 - p)) & 64'hF_FFFF_FFFF_FFFF);
    endfunction

    function automatic rng_word_t compute_rng_word(logic [2:0] func, logic [47:0] sv,
                                                   logic [31:0] b);
        rng_word_t w;
        logic [31:0] d;
        logic [63:0] hi;
        w = '0;
        case (func)
            FUNC_RESEED: model_seed = sv ^ LCG_MULT;
            FUNC_INT32: begin
                d = next_bits(32);
                w.value = {{32{d[31]}}, d};
            end
            FUNC_BOUNDED: begin
                if (b[31]) begin
                    w.bad_bound = 1'b1;
                    bad_bound_count++;
                end else begin
                    w.value = 64'(bounded_draw(b));
                end
            end
            FUNC_INT64: begin
                d = next_bits(32);
                hi = {d, 32'd0};
                d = next_bits(32);
                w.value = hi + {{32{d[31]}}, d};
            end
            FUNC_BOOL: w.value = 64'(next_bits(1));
            FUNC_FLOAT: w.value = float_pattern();
            FUNC_DOUBLE: w.value = double_pattern();
            default: ;
        endcase
        return w;
    endfunction

    // Seed word that makes the next draw leave the seed at target
    function automatic logic [47:0] reseed_reaching(logic [47:0] target);
        logic [47:0] inv;
        inv = LCG_MULT;
        repeat (6) inv = inv * (48'd2 - LCG_MULT * inv);
        return ((target - LCG_INC) * inv) ^ LCG_MULT;
    endfunction

    // Send one request word, hold it until taken, then record the expected result
    task automatic send_word(input logic [2:0] func, input logic [47:0] sv,
                             input logic [31:0] b);
        if (in_gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_seed_value <= sv;
        i_bound <= b;
        do @(posedge i_clk); while (o_in_stall);
        rng_results_due.push_back(compute_rng_word(func, sv, b));
        func_hits[func]++;
    endtask

    // Drop valid and hold off until every owed result word has come back
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (rng_results_due.size() != 0);
    endtask

    function automatic logic [47:0] rand_seed_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mix of bound classes: zero, negative, powers of two, small, wide, rejection-prone
    function automatic logic [31:0] rand_bound();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5)
            return 32'd0;
        if (k < 13)
            return {1'b1, 31'($urandom)};
        if (k < 25)
            return 32'd1 << $urandom_range(0, 30);
        if (k < 50)
            return 32'($urandom_range(1, 100));
        if (k < 70)
            return {1'b0, 31'($urandom)};
        if (k < 85)
            return 32'h4000_0000 + 32'($urandom_range(1, 1 << 20));
        return 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
    endfunction

    // Check each result word against the oldest expectation; pick output stalls
    always @(posedge i_clk) begin : check_results
        rng_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rng_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word value=%h bad_bound=%b",
                             $time, o_value, o_bad_bound);
            end else begin
                want = rng_results_due.pop_front();
                words_checked++;
                if (o_value !== want.value) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: value mismatch expected=%h actual=%h",
                                 $time, want.value, o_value);
                end
                if (o_bad_bound !== want.bad_bound) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: bad_bound mismatch expected=%b actual=%b",
                                 $time, want.bad_bound, o_bad_bound);
                end
            end
        end
        if (out_gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    task automatic test_basic_requests();
        send_word(FUNC_INT32, '0, '0);
        send_word(FUNC_BOOL, '0, '0);
        send_word(FUNC_INT64, '0, '0);
        send_word(FUNC_FLOAT, '0, '0);
        send_word(FUNC_DOUBLE, '0, '0);
    endtask

    task automatic test_bounded_edges();
        send_word(FUNC_BOUNDED, '0, 32'd0);
        send_word(FUNC_BOUNDED, '0, 32'd1);
        send_word(FUNC_BOUNDED, '0, 32'h4000_0000);
        send_word(FUNC_BOUNDED, '0, 32'd3);
        send_word(FUNC_BOUNDED, '0, 32'h7FFF_FFFF);
        send_word(FUNC_BOUNDED, '0, 32'h4000_0001);
        send_word(FUNC_BOUNDED, '0, 32'h8000_0000);
        send_word(FUNC_BOUNDED, '0, 32'hFFFF_FFFF);
    endtask

    // Extreme seeds, and seeds that force zero and smallest float draws
    task automatic test_reseed_edges();
        send_word(FUNC_RESEED, 48'd0, '0);
        send_word(FUNC_INT32, '0, '0);
        send_word(FUNC_RESEED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_DOUBLE, '0, '0);
        send_word(FUNC_RESEED, reseed_reaching(48'd0), '0);
        send_word(FUNC_FLOAT, '0, '0);
        send_word(FUNC_RESEED, reseed_reaching(48'd0), '0);
        send_word(FUNC_DOUBLE, '0, '0);
        send_word(FUNC_RESEED, reseed_reaching(48'h0000_0100_0000), '0);
        send_word(FUNC_FLOAT, '0, '0);
        send_word(FUNC_RESEED, reseed_reaching(48'd0), '0);
        send_word(FUNC_INT64, '0, '0);
    endtask

    // The unused code must leave the seed alone
    task automatic test_unused_code();
        send_word(FUNC_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_INT32, '0, '0);
    endtask

    task automatic test_random_mix(input int count, input bit vary_gaps);
        int sent;
        int k;
        logic [2:0] func;
        logic [2:0] plain_funcs[5];
        logic [47:0] sv;
        plain_funcs = '{FUNC_INT32, FUNC_INT64, FUNC_BOOL, FUNC_FLOAT, FUNC_DOUBLE};
        sent = 0;
        while (sent < count) begin
            k = $urandom_range(0, 99);
            if (k < 5)
                func = FUNC_RESEED;
            else if (k < 8)
                func = FUNC_UNUSED;
            else if (k < 28)
                func = FUNC_BOUNDED;
            else
                func = plain_funcs[$urandom_range(0, 4)];
            sv = rand_seed_word();
            if (func == FUNC_RESEED && $urandom_range(0, 3) == 0)
                sv = reseed_reaching({24'd0, 24'($urandom)});
            send_word(func, sv, rand_bound());
            if (func != FUNC_UNUSED)
                sent++;
            // Switch idling on and off now and then for quiet stretches
            if (vary_gaps && sent % 50 == 0) begin
                if (in_gaps_on !== 1'b0 && $urandom_range(0, 1) == 0) begin
                    in_gaps_on = $urandom_range(0, 1);
                    out_gaps_on = $urandom_range(0, 1);
                end else begin
                    in_gaps_on = 1'b1;
                    out_gaps_on = 1'b1;
                end
            end
        end
    endtask

    // Send a short burst, then hold off until the block has emptied
    task automatic test_pause_drain();
        repeat (4) send_word(FUNC_BOUNDED, '0, rand_bound());
        wait_until_drained();
        send_word(FUNC_DOUBLE, '0, '0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
        test_basic_requests();
        test_bounded_edges();
        test_reseed_edges();
        test_unused_code();
        test_pause_drain();
        test_random_mix(1300, 1'b1);
        wait_until_drained();
        // No idling on either side for the last part
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
        test_random_mix(300, 1'b0);
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rng_results_due.size() != 0)
            mismatch_count++;
        $display("Run covered %0d requests: %0d reseeds, %0d bounded (%0d redraws, %0d negative),",
                 words_checked, func_hits[FUNC_RESEED], func_hits[FUNC_BOUNDED],
                 redraw_count, bad_bound_count);
        $display("%0d int32, %0d int64, %0d boolean, %0d float, %0d double, %0d zero fp draws",
                 func_hits[FUNC_INT32], func_hits[FUNC_INT64], func_hits[FUNC_BOOL],
                 func_hits[FUNC_FLOAT], func_hits[FUNC_DOUBLE], zero_fp_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // End the run if it hangs
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lcg48_pkg.sv
hw/rtl/lcg48_random_generator.sv
tb/tb_lcg48_random_generator.sv
